[hw/rtl/fpsa_pkg.sv]
// Shared constants for the fit-policy segment allocator.
// Holds default table depths, field widths, status, policy and register codes.
// No dependencies.
`timescale 1ns / 1ps

package fpsa_pkg;

    localparam int unsigned FREE_ENTRIES_DEF = 64;
    localparam int unsigned USED_ENTRIES_DEF = 64;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POLICY_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;

    localparam logic [POLICY_W-1:0] POL_FIRST  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST   = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST  = 2'd2;
    localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 1'b1;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_DEALLOC = 1'b1;

endpackage

[hw/rtl/fit_policy_segment_allocator_core.sv]
// Fit-policy segment allocator: address-sorted free and allocated tables in
// single-port-read memories, walked by one sequencer. Depends on fpsa_pkg.
`timescale 1ns / 1ps

// An item is taken only while the block is idle, and one result comes out for
// each item. Every table walk reads one entry per cycle through the single read
// port of its memory, so the item time follows the table fill: an allocate walks
// the fit scan, sorted position scan, insert shift, remove shift (on an exact fit)
// and largest-segment scan, a deallocate the find scan, remove shift, sorted
// position scan, insert shift and largest-segment scan, and a rejected item
// ends with a largest-segment scan. Both tables start empty after reset,
// so no clearing pass is needed; writing region_size reinitializes them.
// Configuration is taken only while idle, and a pending register write
// holds off the item channel.
module fit_policy_segment_allocator_core #(
    parameter int unsigned FREE_ENTRIES = fpsa_pkg::FREE_ENTRIES_DEF,
    parameter int unsigned USED_ENTRIES = fpsa_pkg::USED_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           kind,
    input  logic [fpsa_pkg::ADDR_W-1:0]    req_size,
    input  logic [fpsa_pkg::ADDR_W-1:0]    block_addr,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [fpsa_pkg::STATUS_W-1:0]  status,
    output logic [fpsa_pkg::ADDR_W-1:0]    granted_addr,
    output logic [fpsa_pkg::ADDR_W-1:0]    largest_free,
    output logic [fpsa_pkg::ADDR_W-1:0]    total_free,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fpsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fpsa_pkg::ADDR_W-1:0]    cfg_data
);

    localparam int unsigned AW   = fpsa_pkg::ADDR_W;
    localparam int unsigned DW   = 2 * AW;
    localparam int unsigned FIW  = $clog2(FREE_ENTRIES);
    localparam int unsigned UIW  = $clog2(USED_ENTRIES);
    localparam int unsigned MAXN = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
    localparam int unsigned CW   = $clog2(MAXN + 1);
    localparam int unsigned POLICY_W_L = fpsa_pkg::POLICY_W;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_FSCAN = 14'b00000000000010,
        S_UPOS  = 14'b00000000000100,
        S_USHUP = 14'b00000000001000,
        S_UWR   = 14'b00000000010000,
        S_FSHDN = 14'b00000000100000,
        S_UFIND = 14'b00000001000000,
        S_USHDN = 14'b00000010000000,
        S_FPOS  = 14'b00000100000000,
        S_FSHUP = 14'b00001000000000,
        S_FWR   = 14'b00010000000000,
        S_LSCAN = 14'b00100000000000,
        S_DONE  = 14'b01000000000000,
        S_SPARE = 14'b10000000000000
    } state_t;

    logic [DW-1:0] free_mem [FREE_ENTRIES];
    logic [DW-1:0] used_mem [USED_ENTRIES];
    logic [DW-1:0] f_rdata_reg;
    logic [DW-1:0] u_rdata_reg;

    logic          f_we, u_we;
    logic [FIW-1:0] f_waddr, f_raddr;
    logic [UIW-1:0] u_waddr, u_raddr;
    logic [DW-1:0] f_wdata, u_wdata;

    state_t state_reg, state_next;
    logic [POLICY_W_L-1:0] policy_reg, policy_next;

    logic [CW-1:0] f_cnt_reg, f_cnt_next;
    logic [CW-1:0] u_cnt_reg, u_cnt_next;
    logic [AW-1:0] total_reg, total_next;

    logic [CW-1:0] ridx_reg, ridx_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic          posf_reg, posf_next;
    logic [CW-1:0] pick_reg, pick_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [AW-1:0] pick_start_reg, pick_start_next;
    logic [AW-1:0] pick_len_reg, pick_len_next;
    logic [AW-1:0] largest_reg, largest_next;

    logic [AW-1:0] size_reg, size_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [fpsa_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [AW-1:0] grant_reg, grant_next;

    logic          rv_reg, rv_next;
    logic [fpsa_pkg::STATUS_W-1:0] ost_reg, ost_next;
    logic [AW-1:0] ogrant_reg, ogrant_next;
    logic [AW-1:0] olarge_reg, olarge_next;
    logic [AW-1:0] ototal_reg, ototal_next;

    logic [AW-1:0] fr_st, fr_len, ur_st, ur_len;
    logic          in_scan;
    logic [CW-1:0] scan_lim;
    logic          scan_issue, scan_done;
    logic [CW-1:0] ridx_m1, pidx_p1, pidx_m1, pick_p1;
    logic          item_take;

    assign cfg_ready  = (state_reg == S_IDLE);
    assign item_stall = (state_reg != S_IDLE) || cfg_valid;
    assign item_take  = item_valid && !item_stall;

    assign result_valid = rv_reg;
    assign status       = ost_reg;
    assign granted_addr = ogrant_reg;
    assign largest_free = olarge_reg;
    assign total_free   = ototal_reg;

    assign fr_st  = f_rdata_reg[DW-1:AW];
    assign fr_len = f_rdata_reg[AW-1:0];
    assign ur_st  = u_rdata_reg[DW-1:AW];
    assign ur_len = u_rdata_reg[AW-1:0];

    assign ridx_m1 = ridx_reg - 1'b1;
    assign pidx_p1 = pidx_reg + 1'b1;
    assign pidx_m1 = pidx_reg - 1'b1;
    assign pick_p1 = pick_reg + 1'b1;

    assign in_scan = (state_reg == S_FSCAN) || (state_reg == S_UPOS) ||
                     (state_reg == S_UFIND) || (state_reg == S_FPOS) ||
                     (state_reg == S_LSCAN);
    assign scan_lim   = ((state_reg == S_UPOS) || (state_reg == S_UFIND)) ? u_cnt_reg : f_cnt_reg;
    assign scan_issue = ridx_reg < scan_lim;
    assign scan_done  = !pend_reg && !scan_issue;

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            free_mem[f_waddr] <= f_wdata;
        end
        f_rdata_reg <= free_mem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (u_we)
        begin
            used_mem[u_waddr] <= u_wdata;
        end
        u_rdata_reg <= used_mem[u_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        f_cnt_next      = f_cnt_reg;
        u_cnt_next      = u_cnt_reg;
        total_next      = total_reg;
        ridx_next       = ridx_reg;
        pidx_next       = pidx_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        posf_next       = posf_reg;
        pick_next       = pick_reg;
        pos_next        = pos_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        largest_next    = largest_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        st_next         = st_reg;
        grant_next      = grant_reg;
        rv_next         = rv_reg;
        ost_next        = ost_reg;
        ogrant_next     = ogrant_reg;
        olarge_next     = olarge_reg;
        ototal_next     = ototal_reg;

        f_we    = 1'b0;
        f_waddr = '0;
        f_wdata = '0;
        f_raddr = ridx_reg[FIW-1:0];
        u_we    = 1'b0;
        u_waddr = '0;
        u_wdata = '0;
        u_raddr = ridx_reg[UIW-1:0];

        // drop the result once the consumer takes it
        if (rv_reg && !result_stall)
        begin
            rv_next = 1'b0;
        end

        // scan walks issue one read per cycle and evaluate it in the next cycle
        if (in_scan)
        begin
            if (scan_issue)
            begin
                pend_next = 1'b1;
                pidx_next = ridx_reg;
                ridx_next = ridx_reg + 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_index == fpsa_pkg::REG_FIT_POLICY)
                    begin
                        policy_next = cfg_data[POLICY_W_L-1:0];
                    end
                    else
                    begin
                        u_cnt_next = '0;
                        total_next = cfg_data;
                        f_we       = 1'b1;
                        f_waddr    = '0;
                        f_wdata    = {{AW{1'b0}}, cfg_data};
                        f_cnt_next = (cfg_data != '0) ? CW'(1) : '0;
                    end
                end
                else if (item_take)
                begin
                    size_next    = req_size;
                    addr_next    = block_addr;
                    ridx_next    = '0;
                    pend_next    = 1'b0;
                    found_next   = 1'b0;
                    posf_next    = 1'b0;
                    largest_next = '0;
                    grant_next   = '0;
                    st_next      = fpsa_pkg::ST_OK;
                    if (kind == fpsa_pkg::KIND_DEALLOC)
                    begin
                        state_next = S_UFIND;
                    end
                    else if (req_size == '0)
                    begin
                        st_next    = fpsa_pkg::ST_ZERO;
                        state_next = S_LSCAN;
                    end
                    else if (policy_reg == fpsa_pkg::POL_UNUSED)
                    begin
                        st_next    = fpsa_pkg::ST_NOFIT;
                        state_next = S_LSCAN;
                    end
                    else
                    begin
                        state_next = S_FSCAN;
                    end
                end
            end

            S_FSCAN:
            begin
                if (pend_reg && (fr_len >= size_reg))
                begin
                    if (!found_reg ||
                        ((policy_reg == fpsa_pkg::POL_BEST) && (fr_len < pick_len_reg)) ||
                        ((policy_reg == fpsa_pkg::POL_WORST) && (fr_len > pick_len_reg)))
                    begin
                        found_next      = 1'b1;
                        pick_next       = pidx_reg;
                        pick_start_next = fr_st;
                        pick_len_next   = fr_len;
                    end
                end
                if (scan_done)
                begin
                    ridx_next = '0;
                    if (!found_reg)
                    begin
                        st_next    = fpsa_pkg::ST_NOFIT;
                        state_next = S_LSCAN;
                    end
                    else if (u_cnt_reg >= CW'(USED_ENTRIES))
                    begin
                        st_next    = fpsa_pkg::ST_FULL;
                        state_next = S_LSCAN;
                    end
                    else
                    begin
                        posf_next  = 1'b0;
                        state_next = S_UPOS;
                    end
                end
            end

            S_UPOS:
            begin
                if (pend_reg && !posf_reg && (ur_st >= pick_start_reg))
                begin
                    posf_next = 1'b1;
                    pos_next  = pidx_reg;
                end
                if (scan_done)
                begin
                    pos_next   = posf_reg ? pos_reg : u_cnt_reg;
                    ridx_next  = u_cnt_reg;
                    state_next = S_USHUP;
                end
            end

            S_USHUP:
            begin
                u_raddr   = ridx_m1[UIW-1:0];
                pend_next = 1'b0;
                if (ridx_reg > pos_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ridx_m1;
                    ridx_next = ridx_m1;
                end
                if (pend_reg)
                begin
                    u_we    = 1'b1;
                    u_waddr = pidx_p1[UIW-1:0];
                    u_wdata = u_rdata_reg;
                end
                if (!pend_reg && (ridx_reg <= pos_reg))
                begin
                    state_next = S_UWR;
                end
            end

            S_UWR:
            begin
                u_we       = 1'b1;
                u_waddr    = pos_reg[UIW-1:0];
                u_wdata    = {pick_start_reg, size_reg};
                u_cnt_next = u_cnt_reg + 1'b1;
                total_next = total_reg - size_reg;
                grant_next = pick_start_reg;
                st_next    = fpsa_pkg::ST_OK;
                pend_next  = 1'b0;
                if (pick_len_reg == size_reg)
                begin
                    ridx_next  = pick_p1;
                    state_next = S_FSHDN;
                end
                else
                begin
                    f_we       = 1'b1;
                    f_waddr    = pick_reg[FIW-1:0];
                    f_wdata    = {pick_start_reg + size_reg, pick_len_reg - size_reg};
                    ridx_next  = '0;
                    state_next = S_LSCAN;
                end
            end

            S_FSHDN:
            begin
                pend_next = 1'b0;
                if (ridx_reg < f_cnt_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ridx_reg;
                    ridx_next = ridx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    f_we    = 1'b1;
                    f_waddr = pidx_m1[FIW-1:0];
                    f_wdata = f_rdata_reg;
                end
                if (!pend_reg && (ridx_reg >= f_cnt_reg))
                begin
                    f_cnt_next = f_cnt_reg - 1'b1;
                    ridx_next  = '0;
                    state_next = S_LSCAN;
                end
            end

            S_UFIND:
            begin
                if (pend_reg && !found_reg && (ur_st == addr_reg))
                begin
                    found_next    = 1'b1;
                    pick_next     = pidx_reg;
                    pick_len_next = ur_len;
                end
                if (scan_done)
                begin
                    if (!found_reg)
                    begin
                        st_next    = fpsa_pkg::ST_NOTFOUND;
                        ridx_next  = '0;
                        state_next = S_LSCAN;
                    end
                    else if (f_cnt_reg >= CW'(FREE_ENTRIES))
                    begin
                        st_next    = fpsa_pkg::ST_FULL;
                        ridx_next  = '0;
                        state_next = S_LSCAN;
                    end
                    else
                    begin
                        ridx_next  = pick_p1;
                        state_next = S_USHDN;
                    end
                end
            end

            S_USHDN:
            begin
                pend_next = 1'b0;
                if (ridx_reg < u_cnt_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ridx_reg;
                    ridx_next = ridx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    u_we    = 1'b1;
                    u_waddr = pidx_m1[UIW-1:0];
                    u_wdata = u_rdata_reg;
                end
                if (!pend_reg && (ridx_reg >= u_cnt_reg))
                begin
                    u_cnt_next = u_cnt_reg - 1'b1;
                    ridx_next  = '0;
                    posf_next  = 1'b0;
                    state_next = S_FPOS;
                end
            end

            S_FPOS:
            begin
                if (pend_reg && !posf_reg && (fr_st >= addr_reg))
                begin
                    posf_next = 1'b1;
                    pos_next  = pidx_reg;
                end
                if (scan_done)
                begin
                    pos_next   = posf_reg ? pos_reg : f_cnt_reg;
                    ridx_next  = f_cnt_reg;
                    state_next = S_FSHUP;
                end
            end

            S_FSHUP:
            begin
                f_raddr   = ridx_m1[FIW-1:0];
                pend_next = 1'b0;
                if (ridx_reg > pos_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ridx_m1;
                    ridx_next = ridx_m1;
                end
                if (pend_reg)
                begin
                    f_we    = 1'b1;
                    f_waddr = pidx_p1[FIW-1:0];
                    f_wdata = f_rdata_reg;
                end
                if (!pend_reg && (ridx_reg <= pos_reg))
                begin
                    state_next = S_FWR;
                end
            end

            S_FWR:
            begin
                f_we       = 1'b1;
                f_waddr    = pos_reg[FIW-1:0];
                f_wdata    = {addr_reg, pick_len_reg};
                f_cnt_next = f_cnt_reg + 1'b1;
                total_next = total_reg + pick_len_reg;
                st_next    = fpsa_pkg::ST_OK;
                ridx_next  = '0;
                pend_next  = 1'b0;
                state_next = S_LSCAN;
            end

            S_LSCAN:
            begin
                if (pend_reg && (fr_len > largest_reg))
                begin
                    largest_next = fr_len;
                end
                if (scan_done)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!rv_reg || !result_stall)
                begin
                    rv_next     = 1'b1;
                    ost_next    = st_reg;
                    ogrant_next = (st_reg == fpsa_pkg::ST_OK) ? grant_reg : '0;
                    olarge_next = largest_reg;
                    ototal_next = total_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            policy_reg <= fpsa_pkg::POL_FIRST;
            f_cnt_reg  <= '0;
            u_cnt_reg  <= '0;
            total_reg  <= '0;
            ridx_reg   <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            posf_reg   <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            policy_reg <= policy_next;
            f_cnt_reg  <= f_cnt_next;
            u_cnt_reg  <= u_cnt_next;
            total_reg  <= total_next;
            ridx_reg   <= ridx_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            posf_reg   <= posf_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        pick_reg       <= pick_next;
        pos_reg        <= pos_next;
        pick_start_reg <= pick_start_next;
        pick_len_reg   <= pick_len_next;
        largest_reg    <= largest_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        st_reg         <= st_next;
        grant_reg      <= grant_next;
        ost_reg        <= ost_next;
        ogrant_reg     <= ogrant_next;
        olarge_reg     <= olarge_next;
        ototal_reg     <= ototal_next;
    end

endmodule

[hw/rtl/fpsa_checker.sv]
// Port-level checks for the fit-policy segment allocator, bound to the allocator core.
// Depends on fpsa_pkg and fit_policy_segment_allocator_core.
`timescale 1ns / 1ps

module fpsa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_stall,
    input logic                           result_valid,
    input logic                           result_stall,
    input logic [fpsa_pkg::STATUS_W-1:0]  status,
    input logic [fpsa_pkg::ADDR_W-1:0]    granted_addr,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    // status code stays within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status <= fpsa_pkg::ST_ZERO))
        else $error("status code out of range");

    // a failed item never reports a granted address
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != fpsa_pkg::ST_OK)) |-> (granted_addr == '0))
        else $error("granted address on failed item");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(status)))
        else $error("stalled result changed");

    // no item transfer in the same cycle as a register write
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> !(item_valid && !item_stall))
        else $error("item accepted during register write");

endmodule

bind fit_policy_segment_allocator_core fpsa_checker u_fpsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .granted_addr (granted_addr),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
